@@ rtl/qte_pkg.sv @@
// Package for the quaternion to Euler angle block: types, widths, CORDIC angle table.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int SQRT_STAGES   = 29;
	localparam int DW            = 36;
	localparam int ZW            = 34;
	localparam int ARG_W         = 30;
	localparam int ROOT_W        = SQRT_STAGES;
	localparam int REM_W         = SQRT_STAGES + 1;
	localparam int RAD_W         = 2 * SQRT_STAGES;
	localparam int VW            = ZW - 15;

	localparam logic signed [DW-1:0] ONE_Q28 = DW'(64'sd268435456);
	localparam logic signed [ZW-1:0] ANG_PI  = ZW'(64'sd1073741824);
	localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(64'sd16384);
	localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(1) << (2 * ROOT_W - 2);

	localparam logic signed [VW-1:0] ANGLE_MIN = -VW'(64'sd32768);
	localparam logic signed [VW-1:0] ANGLE_MAX = VW'(64'sd32767);
	localparam logic signed [VW-1:0] PITCH_MIN = -VW'(64'sd16384);
	localparam logic signed [VW-1:0] PITCH_MAX = VW'(64'sd16384);

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} qte_in_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} qte_out_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cordic_t;

	typedef struct packed {
		logic [RAD_W-1:0]        rad;
		logic [REM_W-1:0]        rem;
		logic [ROOT_W-1:0]       root;
		logic signed [ARG_W-1:0] arg;
	} sqrt_t;

	// atan(2^-i), pi = 2^30
	function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:  r = ZW'(64'sd268435456);
			5'd1:  r = ZW'(64'sd158466703);
			5'd2:  r = ZW'(64'sd83729454);
			5'd3:  r = ZW'(64'sd42502379);
			5'd4:  r = ZW'(64'sd21333666);
			5'd5:  r = ZW'(64'sd10677233);
			5'd6:  r = ZW'(64'sd5339919);
			5'd7:  r = ZW'(64'sd2670123);
			5'd8:  r = ZW'(64'sd1335082);
			5'd9:  r = ZW'(64'sd667543);
			5'd10: r = ZW'(64'sd333772);
			5'd11: r = ZW'(64'sd166886);
			5'd12: r = ZW'(64'sd83443);
			5'd13: r = ZW'(64'sd41722);
			5'd14: r = ZW'(64'sd20861);
			5'd15: r = ZW'(64'sd10430);
			5'd16: r = ZW'(64'sd5215);
			5'd17: r = ZW'(64'sd2608);
			5'd18: r = ZW'(64'sd1304);
			5'd19: r = ZW'(64'sd652);
			5'd20: r = ZW'(64'sd326);
			5'd21: r = ZW'(64'sd163);
			5'd22: r = ZW'(64'sd81);
			5'd23: r = ZW'(64'sd41);
			default: r = '0;
		endcase
		return r;
	endfunction

	// round to binary angle units and saturate; a zero vector gives 0
	function automatic logic signed [15:0] to_angle(input logic signed [ZW-1:0] z,
			input logic zero, input logic signed [VW-1:0] lo, input logic signed [VW-1:0] hi);
		logic signed [ZW-1:0] s;
		logic signed [VW-1:0] v;
		logic signed [15:0] r;
		s = z + ROUND_HALF;
		v = s[ZW-1:15];
		if (zero) begin
			r = '0;
		end else if (v < lo) begin
			r = lo[15:0];
		end else if (v > hi) begin
			r = hi[15:0];
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/qte_sqrt_cell.sv @@
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt_cell (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire qte_pkg::sqrt_t d,
	output qte_pkg::sqrt_t      q
);
	import qte_pkg::*;

	sqrt_t cell_q;
	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	sqrt_t nxt;

	always_comb begin
		rem_sh = {d.rem, d.rad[RAD_W-1:RAD_W-2]};
		trial  = {1'b0, d.root, 2'b01};
		diff   = rem_sh - trial;
		nxt.rad = {d.rad[RAD_W-3:0], 2'b00};
		nxt.arg = d.arg;
		if (rem_sh >= trial) begin
			nxt.rem  = diff[REM_W-1:0];
			nxt.root = {d.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh[REM_W-1:0];
			nxt.root = {d.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;
endmodule
`default_nettype wire

@@ rtl/qte_cordic_prep.sv @@
// CORDIC entry stage: folds the vector into the right half plane, flags a zero vector.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_prep (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic signed [qte_pkg::DW-1:0] vy,
	input  wire logic signed [qte_pkg::DW-1:0] vx,
	output qte_pkg::cordic_t                 q
);
	import qte_pkg::*;

	cordic_t prep_q;
	cordic_t nxt;

	always_comb begin
		nxt.zero = (vx == '0) && (vy == '0);
		if (vx < 0) begin
			nxt.x = -vx;
			nxt.y = -vy;
			nxt.z = (vy >= 0) ? ANG_PI : -ANG_PI;
		end else begin
			nxt.x = vx;
			nxt.y = vy;
			nxt.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_q <= nxt;
		end
	end

	assign q = prep_q;
endmodule
`default_nettype wire

@@ rtl/qte_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation cell.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [4:0]       stage,
	input  wire qte_pkg::cordic_t d,
	output qte_pkg::cordic_t      q
);
	import qte_pkg::*;

	cordic_t cell_q;
	cordic_t nxt;
	logic signed [DW-1:0] xs;
	logic signed [DW-1:0] ys;
	logic signed [ZW-1:0] step;

	always_comb begin
		xs = d.x >>> stage;
		ys = d.y >>> stage;
		step = atan_step(stage);
		nxt.zero = d.zero;
		if (!d.y[DW-1]) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + step;
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - step;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;
endmodule
`default_nettype wire

@@ rtl/quaternion_to_euler_angles_top.sv @@
// Top level: quaternion (Q2.14) to roll, pitch, yaw in binary angle units.
// Usage:
//   Input channel quat / quat_valid / quat_stall carries one unit quaternion
//   per transfer. Output channel angles / angles_valid / angles_stall carries
//   roll, pitch and yaw (32768 = pi) per transfer, in input order.
//   Throughput is one transfer per cycle while the output is not stalled.
//   From input transfer to angles_valid the path passes through, in order:
//   products, sums and clamp, square, one minus square, one cell per result
//   bit of the 29-stage square root, one CORDIC entry stage and one cell per
//   CORDIC stage, then the output register. Roll and yaw run alongside the
//   square root and wait in a delay line for pitch.
//   When the receiver stalls while a result sits in the output register, the
//   whole pipeline holds and quat_stall rises; otherwise the input is taken
//   every cycle, including while a result is being handed over.
//   Reset clears all valid flags; the pipeline then holds no transfer.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qte_pkg::qte_in_t  quat,
	input  wire logic              quat_valid,
	output logic                   quat_stall,
	output qte_pkg::qte_out_t      angles,
	output logic                   angles_valid,
	input  wire logic              angles_stall
);
	import qte_pkg::*;

	localparam int VLD_LEN = 4 + SQRT_STAGES + 1 + CORDIC_STAGES;
	localparam int DLY_LEN = SQRT_STAGES + 1;

	logic en;
	logic [VLD_LEN-1:0] vld_q;
	logic angles_valid_q;
	qte_out_t angles_q;

	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic signed [DW-1:0] t0_s2, t1_s2, t3_s2, t4_s2;
	logic signed [ARG_W-1:0] t2c_s2, t2c_s3, t2c_s4;
	logic signed [DW-1:0] t2_raw, t2_clamp;
	logic signed [2*ARG_W-1:0] t2_sq;
	logic [RAD_W-2:0] sq_s3;
	logic [RAD_W-1:0] n_s4;

	sqrt_t sq_chain [SQRT_STAGES+1];
	cordic_t roll_chain [CORDIC_STAGES+1];
	cordic_t yaw_chain [CORDIC_STAGES+1];
	cordic_t pitch_chain [CORDIC_STAGES+1];

	logic signed [15:0] roll_conv_q, yaw_conv_q;
	logic signed [15:0] roll_dly_q [DLY_LEN];
	logic signed [15:0] yaw_dly_q [DLY_LEN];

	assign en = !angles_valid_q || !angles_stall;
	assign quat_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			angles_valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[VLD_LEN-2:0], quat_valid};
			angles_valid_q <= vld_q[VLD_LEN-1];
		end
	end

	always_comb begin
		t2_raw = (DW'(wy_s1) - DW'(zx_s1)) <<< 1;
		if (t2_raw > ONE_Q28) begin
			t2_clamp = ONE_Q28;
		end else if (t2_raw < -ONE_Q28) begin
			t2_clamp = -ONE_Q28;
		end else begin
			t2_clamp = t2_raw;
		end
		t2_sq = (2*ARG_W)'(t2c_s2) * (2*ARG_W)'(t2c_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= 32'(quat.quat_w) * 32'(quat.quat_x);
			yz_s1 <= 32'(quat.quat_y) * 32'(quat.quat_z);
			xx_s1 <= 32'(quat.quat_x) * 32'(quat.quat_x);
			yy_s1 <= 32'(quat.quat_y) * 32'(quat.quat_y);
			wy_s1 <= 32'(quat.quat_w) * 32'(quat.quat_y);
			zx_s1 <= 32'(quat.quat_z) * 32'(quat.quat_x);
			wz_s1 <= 32'(quat.quat_w) * 32'(quat.quat_z);
			xy_s1 <= 32'(quat.quat_x) * 32'(quat.quat_y);
			zz_s1 <= 32'(quat.quat_z) * 32'(quat.quat_z);

			t0_s2 <= (DW'(wx_s1) + DW'(yz_s1)) <<< 1;
			t1_s2 <= ONE_Q28 - ((DW'(xx_s1) + DW'(yy_s1)) <<< 1);
			t3_s2 <= (DW'(wz_s1) + DW'(xy_s1)) <<< 1;
			t4_s2 <= ONE_Q28 - ((DW'(yy_s1) + DW'(zz_s1)) <<< 1);
			t2c_s2 <= t2_clamp[ARG_W-1:0];

			sq_s3 <= t2_sq[RAD_W-2:0];
			t2c_s3 <= t2c_s2;

			n_s4 <= RAD_ONE - {1'b0, sq_s3};
			t2c_s4 <= t2c_s3;
		end
	end

	// square root of 1 - t*t
	assign sq_chain[0] = '{rad: n_s4, rem: '0, root: '0, arg: t2c_s4};

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
		qte_sqrt_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq_chain[i]),
			.q   (sq_chain[i+1])
		);
	end

	qte_cordic_prep u_roll_prep (
		.clk (clk),
		.en  (en),
		.vy  (t0_s2),
		.vx  (t1_s2),
		.q   (roll_chain[0])
	);

	qte_cordic_prep u_yaw_prep (
		.clk (clk),
		.en  (en),
		.vy  (t3_s2),
		.vx  (t4_s2),
		.q   (yaw_chain[0])
	);

	qte_cordic_prep u_pitch_prep (
		.clk (clk),
		.en  (en),
		.vy  (DW'(sq_chain[SQRT_STAGES].arg)),
		.vx  ($signed(DW'(sq_chain[SQRT_STAGES].root))),
		.q   (pitch_chain[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		qte_cordic_cell u_roll (
			.clk   (clk),
			.en    (en),
			.stage (5'(i)),
			.d     (roll_chain[i]),
			.q     (roll_chain[i+1])
		);
		qte_cordic_cell u_yaw (
			.clk   (clk),
			.en    (en),
			.stage (5'(i)),
			.d     (yaw_chain[i]),
			.q     (yaw_chain[i+1])
		);
		qte_cordic_cell u_pitch (
			.clk   (clk),
			.en    (en),
			.stage (5'(i)),
			.d     (pitch_chain[i]),
			.q     (pitch_chain[i+1])
		);
	end

	// roll and yaw wait for the square root path
	always_ff @(posedge clk) begin
		if (en) begin
			roll_conv_q <= to_angle(roll_chain[CORDIC_STAGES].z,
				roll_chain[CORDIC_STAGES].zero, ANGLE_MIN, ANGLE_MAX);
			yaw_conv_q <= to_angle(yaw_chain[CORDIC_STAGES].z,
				yaw_chain[CORDIC_STAGES].zero, ANGLE_MIN, ANGLE_MAX);
			roll_dly_q[0] <= roll_conv_q;
			yaw_dly_q[0] <= yaw_conv_q;
			for (int i = 1; i < DLY_LEN; i++) begin
				roll_dly_q[i] <= roll_dly_q[i-1];
				yaw_dly_q[i] <= yaw_dly_q[i-1];
			end
			angles_q.roll_angle <= roll_dly_q[DLY_LEN-1];
			angles_q.yaw_angle <= yaw_dly_q[DLY_LEN-1];
			angles_q.pitch_angle <= to_angle(pitch_chain[CORDIC_STAGES].z,
				pitch_chain[CORDIC_STAGES].zero, PITCH_MIN, PITCH_MAX);
		end
	end

	assign angles = angles_q;
	assign angles_valid = angles_valid_q;
endmodule
`default_nettype wire
